>>> design/ctt_pkg.sv
package ctt_pkg;

  typedef enum logic [2:0] {
    MODE_IDLE     = 3'd0,
    MODE_COMMENT  = 3'd1,
    MODE_WORD     = 3'd2,
    MODE_STRING   = 3'd3,
    MODE_ESCAPE   = 3'd4,
    MODE_DONE     = 3'd5,
    MODE_ERR_LONG = 3'd6,
    MODE_ERR_STR  = 3'd7
  } lex_mode_e;

  localparam logic [2:0] KIND_EOF      = 3'd0;
  localparam logic [2:0] KIND_NEWLINE  = 3'd1;
  localparam logic [2:0] KIND_EQUALS   = 3'd2;
  localparam logic [2:0] KIND_LBRACKET = 3'd3;
  localparam logic [2:0] KIND_RBRACKET = 3'd4;
  localparam logic [2:0] KIND_WORD     = 3'd5;
  localparam logic [2:0] KIND_STRING   = 3'd6;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_TOO_LONG = 2'd1;
  localparam logic [1:0] ERR_UNTERM   = 2'd2;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_EQ    = 8'h3d;
  localparam logic [7:0] CH_LBR   = 8'h5b;
  localparam logic [7:0] CH_RBR   = 8'h5d;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_BSL   = 8'h5c;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_N     = 8'h6e;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_R     = 8'h72;

  localparam logic [15:0] LINE_MAX = 16'hffff;

  // output queue depth, room for two results per transaction
  localparam int unsigned OUT_DEPTH = 4;

  typedef struct packed {
    logic [2:0]  token_kind;
    logic [7:0]  text_byte;
    logic        text_valid;
    logic        token_end;
    logic [1:0]  error_code;
    logic [15:0] line_number;
  } res_t;

  typedef struct packed {
    lex_mode_e   mode;
    logic        quote_kind;
    logic [15:0] line_counter;
  } lex_state_t;

  function automatic logic is_blank(input logic [7:0] b);
    return b inside {CH_SPACE, CH_TAB, CH_CR};
  endfunction

  function automatic logic is_word_byte(input logic [7:0] b);
    return !(b inside {CH_NUL, CH_LF, CH_SPACE, CH_TAB, CH_CR, CH_HASH, CH_EQ,
                       CH_LBR, CH_RBR, CH_DQ, CH_SQ});
  endfunction

  function automatic logic [7:0] map_escape(input logic [7:0] b);
    logic [7:0] m;
    case (b)
      CH_N:    m = CH_LF;
      CH_T:    m = CH_TAB;
      CH_R:    m = CH_CR;
      default: m = b;
    endcase
    return m;
  endfunction

  function automatic logic [1:0] err_of(input lex_mode_e mode);
    logic [1:0] e;
    case (mode)
      MODE_ERR_LONG: e = ERR_TOO_LONG;
      MODE_ERR_STR:  e = ERR_UNTERM;
      default:       e = ERR_NONE;
    endcase
    return e;
  endfunction

  function automatic res_t mk_res(input logic [2:0] kind, input logic [7:0] b,
                                  input logic valid, input logic last,
                                  input lex_mode_e mode, input logic [15:0] line);
    res_t r;
    r.token_kind  = kind;
    r.text_byte   = b;
    r.text_valid  = valid;
    r.token_end   = last;
    r.error_code  = err_of(mode);
    r.line_number = line;
    return r;
  endfunction

endpackage

>>> design/ctt_if.sv
interface ctt_in_if;
  import ctt_pkg::*;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_input;

  modport source (output valid, output in_byte, output end_of_input, input ready);
  modport sink (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface ctt_out_if;
  import ctt_pkg::*;
  logic        valid;
  logic        ready;
  logic [2:0]  token_kind;
  logic [7:0]  text_byte;
  logic        text_valid;
  logic        token_end;
  logic [1:0]  error_code;
  logic [15:0] line_number;

  modport source (output valid, output token_kind, output text_byte, output text_valid,
                  output token_end, output error_code, output line_number, input ready);
  modport sink (input valid, input token_kind, input text_byte, input text_valid,
                input token_end, input error_code, input line_number, output ready);
endinterface

>>> design/ctt_lex_step.sv
module ctt_lex_step import ctt_pkg::*; #(
  parameter int unsigned MAX_TOKEN_LEN = 64,
  parameter int unsigned LenW = $clog2(MAX_TOKEN_LEN)
) (
  input  lex_state_t      st_i,
  input  logic [LenW-1:0] len_i,
  input  logic [7:0]      in_byte_i,
  input  logic            eoi_i,
  output lex_state_t      st_o,
  output logic [LenW-1:0] len_o,
  output res_t            res_o [2],
  output logic [1:0]      n_res_o
);

  localparam logic [LenW-1:0] LenLimit = LenW'(MAX_TOKEN_LEN - 1);

  lex_state_t      st_d;
  logic [LenW-1:0] len_d;
  res_t            res [2];
  logic [1:0]      n_res;
  logic            do_idle;
  logic            do_push;
  logic [2:0]      push_kind;
  logic [7:0]      push_byte;
  logic [LenW-1:0] push_base;

  always_comb begin
    st_d      = st_i;
    len_d     = len_i;
    res[0]    = '0;
    res[1]    = '0;
    n_res     = 2'd0;
    do_idle   = 1'b0;
    do_push   = 1'b0;
    push_kind = KIND_WORD;
    push_byte = '0;
    push_base = len_i;

    if (eoi_i) begin
      if (st_i.mode == MODE_WORD) begin
        st_d.mode = MODE_IDLE;
        res[n_res[0]] = mk_res(KIND_WORD, '0, 1'b0, 1'b1, st_d.mode, st_d.line_counter);
        n_res = n_res + 2'd1;
      end else if (st_i.mode == MODE_STRING || st_i.mode == MODE_ESCAPE) begin
        st_d.mode = MODE_ERR_STR;
        res[n_res[0]] = mk_res(KIND_STRING, '0, 1'b0, 1'b1, st_d.mode, st_d.line_counter);
        n_res = n_res + 2'd1;
      end
      if (st_d.mode != MODE_ERR_LONG && st_d.mode != MODE_ERR_STR) begin
        st_d.mode = MODE_DONE;
      end
      res[n_res[0]] = mk_res(KIND_EOF, '0, 1'b0, 1'b1, st_d.mode, st_d.line_counter);
      n_res = n_res + 2'd1;
    end else begin
      case (st_i.mode)
        MODE_IDLE: begin
          do_idle = 1'b1;
        end
        MODE_COMMENT: begin
          if (in_byte_i == CH_LF) begin
            st_d.mode = MODE_IDLE;
            do_idle   = 1'b1;
          end
        end
        MODE_WORD: begin
          if (in_byte_i != CH_NUL) begin
            if (is_word_byte(in_byte_i)) begin
              do_push   = 1'b1;
              push_kind = KIND_WORD;
              push_byte = in_byte_i;
            end else begin
              // boundary byte closes the word, then is lexed as in idle
              st_d.mode = MODE_IDLE;
              res[n_res[0]] = mk_res(KIND_WORD, '0, 1'b0, 1'b1, st_d.mode,
                                     st_d.line_counter);
              n_res   = n_res + 2'd1;
              do_idle = 1'b1;
            end
          end
        end
        MODE_STRING: begin
          if (in_byte_i == (st_i.quote_kind ? CH_SQ : CH_DQ)) begin
            st_d.mode = MODE_IDLE;
            res[n_res[0]] = mk_res(KIND_STRING, '0, 1'b0, 1'b1, st_d.mode,
                                   st_d.line_counter);
            n_res = n_res + 2'd1;
          end else if (in_byte_i == CH_BSL) begin
            st_d.mode = MODE_ESCAPE;
          end else begin
            do_push   = 1'b1;
            push_kind = KIND_STRING;
            push_byte = in_byte_i;
          end
        end
        MODE_ESCAPE: begin
          st_d.mode = MODE_STRING;
          do_push   = 1'b1;
          push_kind = KIND_STRING;
          push_byte = map_escape(in_byte_i);
        end
        default: begin
        end
      endcase

      if (do_idle && in_byte_i != CH_NUL && !is_blank(in_byte_i)) begin
        case (in_byte_i)
          CH_HASH: begin
            st_d.mode = MODE_COMMENT;
          end
          CH_LF: begin
            if (st_d.line_counter != LINE_MAX) begin
              st_d.line_counter = st_d.line_counter + 16'd1;
            end
            res[n_res[0]] = mk_res(KIND_NEWLINE, '0, 1'b0, 1'b1, st_d.mode,
                                   st_d.line_counter);
            n_res = n_res + 2'd1;
          end
          CH_EQ: begin
            res[n_res[0]] = mk_res(KIND_EQUALS, '0, 1'b0, 1'b1, st_d.mode,
                                   st_d.line_counter);
            n_res = n_res + 2'd1;
          end
          CH_LBR: begin
            res[n_res[0]] = mk_res(KIND_LBRACKET, '0, 1'b0, 1'b1, st_d.mode,
                                   st_d.line_counter);
            n_res = n_res + 2'd1;
          end
          CH_RBR: begin
            res[n_res[0]] = mk_res(KIND_RBRACKET, '0, 1'b0, 1'b1, st_d.mode,
                                   st_d.line_counter);
            n_res = n_res + 2'd1;
          end
          CH_DQ, CH_SQ: begin
            st_d.quote_kind = (in_byte_i == CH_SQ);
            len_d           = '0;
            st_d.mode       = MODE_STRING;
          end
          default: begin
            len_d     = '0;
            st_d.mode = MODE_WORD;
            do_push   = 1'b1;
            push_kind = KIND_WORD;
            push_byte = in_byte_i;
            push_base = '0;
          end
        endcase
      end

      if (do_push) begin
        if (push_base >= LenLimit) begin
          st_d.mode = MODE_ERR_LONG;
          res[n_res[0]] = mk_res(push_kind, '0, 1'b0, 1'b1, st_d.mode, st_d.line_counter);
        end else begin
          len_d = push_base + LenW'(1);
          res[n_res[0]] = mk_res(push_kind, push_byte, 1'b1, 1'b0, st_d.mode,
                                 st_d.line_counter);
        end
        n_res = n_res + 2'd1;
      end
    end
  end

  assign st_o     = st_d;
  assign len_o    = len_d;
  assign res_o[0] = res[0];
  assign res_o[1] = res[1];
  assign n_res_o  = n_res;

endmodule

>>> design/ctt_out_fifo.sv
module ctt_out_fifo import ctt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  res_t       push_data_i [2],
  input  logic [1:0] push_cnt_i,
  input  logic       pop_i,
  output res_t       head_o,
  output logic       valid_o,
  output logic       room2_o
);

  localparam int unsigned PtrW = $clog2(OUT_DEPTH);
  localparam int unsigned CntW = $clog2(OUT_DEPTH + 1);

  res_t            mem_q [OUT_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_pop;
  logic [PtrW-1:0] wr_ptr_nx;

  assign valid_o   = (cnt_q != '0);
  assign head_o    = mem_q[rd_ptr_q];
  assign room2_o   = (cnt_q <= CntW'(OUT_DEPTH - 2));
  assign do_pop    = pop_i && valid_o;
  assign wr_ptr_nx = wr_ptr_q + PtrW'(1);

  always_comb begin
    wr_ptr_d = wr_ptr_q + PtrW'(push_cnt_i);
    rd_ptr_d = rd_ptr_q + PtrW'(do_pop);
    cnt_d    = cnt_q + CntW'(push_cnt_i) - CntW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      mem_q[wr_ptr_q] <= push_data_i[0];
    end
    if (push_cnt_i == 2'd2) begin
      mem_q[wr_ptr_nx] <= push_data_i[1];
    end
  end

endmodule

>>> design/config_text_tokenizer.sv
// channel | dir | payload                                        | accepted
// in_i    | in  | in_byte[7:0], end_of_input                     | valid && ready
// out_o   | out | token_kind, text_byte, text_valid, token_end,  | valid && ready
//         |     | error_code, line_number                        |
// one input transaction per cycle; lexing is one combinational pass on the
// accepted byte against the mode registers, results land in a 4-entry queue
// an item gives zero, one or two results; the result side drains one result
// a cycle while out_o.ready is high
// in_i.ready drops while the queue has fewer than two free entries
// asynchronous active-low reset: idle mode, line counter one, queue empty
module config_text_tokenizer import ctt_pkg::*; #(
  parameter int unsigned MAX_TOKEN_LEN = 64
) (
  input logic       clk_i,
  input logic       rst_ni,
  ctt_in_if.sink    in_i,
  ctt_out_if.source out_o
);

  localparam int unsigned LenW = $clog2(MAX_TOKEN_LEN);

  lex_state_t      st_q, st_d;
  logic [LenW-1:0] len_q, len_d;
  res_t            step_res [2];
  logic [1:0]      step_n;
  logic [1:0]      push_cnt;
  logic            in_fire;
  logic            room2;
  res_t            head;

  assign in_i.ready = room2;
  assign in_fire    = in_i.valid && room2;
  assign push_cnt   = in_fire ? step_n : 2'd0;

  ctt_lex_step #(
    .MAX_TOKEN_LEN(MAX_TOKEN_LEN),
    .LenW         (LenW)
  ) u_step (
    .st_i     (st_q),
    .len_i    (len_q),
    .in_byte_i(in_i.in_byte),
    .eoi_i    (in_i.end_of_input),
    .st_o     (st_d),
    .len_o    (len_d),
    .res_o    (step_res),
    .n_res_o  (step_n)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.mode         <= MODE_IDLE;
      st_q.quote_kind   <= 1'b0;
      st_q.line_counter <= 16'd1;
      len_q             <= '0;
    end else if (in_fire) begin
      st_q  <= st_d;
      len_q <= len_d;
    end
  end

  ctt_out_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_data_i(step_res),
    .push_cnt_i (push_cnt),
    .pop_i      (out_o.ready),
    .head_o     (head),
    .valid_o    (out_o.valid),
    .room2_o    (room2)
  );

  assign out_o.token_kind  = head.token_kind;
  assign out_o.text_byte   = head.text_byte;
  assign out_o.text_valid  = head.text_valid;
  assign out_o.token_end   = head.token_end;
  assign out_o.error_code  = head.error_code;
  assign out_o.line_number = head.line_number;

endmodule

>>> design/ctt_checker.sv
module ctt_checker import ctt_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [2:0]  token_kind_i,
  input logic [7:0]  text_byte_i,
  input logic        text_valid_i,
  input logic        token_end_i,
  input logic [1:0]  error_code_i,
  input logic [15:0] line_number_i
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable({token_kind_i, text_byte_i, text_valid_i,
                                             token_end_i, error_code_i, line_number_i}))
    else $error("result payload changed while stalled");

  // sticky error: a later result never reports a cleared error
  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && error_code_i != ERR_NONE
      |=> !out_valid_i || (error_code_i != ERR_NONE && error_code_i == $past(error_code_i)))
    else $error("error code cleared or changed");

  // closing results carry no text, and lines count from one
  a_close_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> line_number_i != 16'd0 && (text_valid_i != token_end_i) &&
                    (text_valid_i || text_byte_i == 8'd0))
    else $error("malformed result");

endmodule

bind config_text_tokenizer ctt_checker u_ctt_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .token_kind_i (out_o.token_kind),
  .text_byte_i  (out_o.text_byte),
  .text_valid_i (out_o.text_valid),
  .token_end_i  (out_o.token_end),
  .error_code_i (out_o.error_code),
  .line_number_i(out_o.line_number)
);
